// File: sv/sasm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick mixer package
// Shared types, constants and codes for the six-axis stick mixer.
// ----------------------------------------------------------------------------
package sasm_pkg;

  localparam int NumChan      = 8;
  localparam int ChanW        = 13;
  localparam int SumW         = 21;
  localparam int FullScale    = 8192;
  localparam int ScaleMax     = 250;

  // Configuration register indexes.
  localparam logic [1:0] RegSamples  = 2'd0;
  localparam logic [1:0] RegCalib    = 2'd1;
  localparam logic [1:0] RegDeadzone = 2'd2;
  localparam logic [1:0] RegInvert   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_SCALE,
    ST_MIX,
    ST_OUT
  } sasm_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       accum;     // add the accepted frame
    logic       div_start; // start a division
    logic       div_sel;   // 0 average division, 1 scale division
    logic [2:0] chan;      // channel under work
    logic       store_avg; // take the quotient as average
    logic       store_ctr; // take the average as center
    logic       store_val; // take the scaled value
    logic       clear_run; // clear sums and count
    logic       mix;       // register the mixed result
  } sasm_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
    logic run_end;    // frame just added ended the run
    logic run_mode;
    logic scale_skip; // scaled value needs no division
  } sasm_status_t;

endpackage

// File: sv/sasm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 24 by 16 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sasm_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [23:0] quotient
);

  logic [23:0] quo;
  logic [16:0] rem;
  logic [15:0] den;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic [16:0] diff;

  // One shift and subtract step.
  always_comb begin
    trial = {rem[15:0], quo[23]};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd24;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      if (!diff[16]) begin
        rem <= diff;
        quo <= {quo[22:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[22:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

// File: sv/sasm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick mixer datapath
// Sums, centers, averaging and scaling divisions, deadzone and axis mixing.
// ----------------------------------------------------------------------------
module sasm_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_op,
  input  logic [8*13-1:0]      in_chan,
  input  sasm_pkg::sasm_cmd_t  cmd,
  output sasm_pkg::sasm_status_t status,
  output logic [60:0]          result
);
  import sasm_pkg::*;

  logic [7:0]      samples_per_report;
  logic [7:0]      calibration_samples;
  logic [7:0]      deadzone;
  logic [5:0]      invert_mask;
  logic [SumW-1:0] sums [NumChan];
  logic [7:0]      frame_count;
  logic            run_mode;
  logic [ChanW-1:0] centers [NumChan];
  logic [ChanW-1:0] avg;
  logic signed [8:0] vals [NumChan];
  logic            run_end;

  logic        div_start;
  logic [23:0] dividend;
  logic [15:0] divisor;
  logic        div_done;
  logic [23:0] quotient;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_report  <= 8'd1;
      calibration_samples <= 8'd100;
      deadzone            <= 8'd3;
      invert_mask         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegSamples:  samples_per_report  <= cfg_data;
        RegCalib:    calibration_samples <= cfg_data;
        RegDeadzone: deadzone            <= cfg_data;
        RegInvert:   invert_mask         <= cfg_data[5:0];
        default:     ;
      endcase
    end
  end

  // Run accumulation and end-of-run detection.
  logic [7:0] count_next;
  logic [7:0] target;
  logic [7:0] count_base;
  always_comb begin
    count_base = (in_op != run_mode) ? 8'd0 : frame_count;
    count_next = count_base + 8'd1;
    target     = in_op ? calibration_samples : samples_per_report;
    if (target == 8'd0) target = 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      run_mode    <= 1'b0;
      run_end     <= 1'b0;
      for (int i = 0; i < NumChan; i++) begin
        sums[i]    <= '0;
        centers[i] <= '0;
      end
    end else begin
      if (cmd.accum) begin
        run_mode    <= in_op;
        frame_count <= count_next;
        run_end     <= (count_next != 8'd0) && (count_next >= target);
        for (int i = 0; i < NumChan; i++) begin
          sums[i] <= ((in_op != run_mode) ? '0 : sums[i])
                     + {8'd0, in_chan[i*ChanW +: ChanW]};
        end
      end else if (cmd.clear_run) begin
        frame_count <= '0;
        run_end     <= 1'b0;
        for (int i = 0; i < NumChan; i++) sums[i] <= '0;
      end
      if (cmd.store_ctr) centers[cmd.chan] <= avg;
    end
  end

  // Scaling operands for the channel under work.
  logic [ChanW-1:0]   ctr;
  logic signed [14:0] d;
  logic [13:0]        dmag;
  logic signed [17:0] den;
  logic               den_bad;
  always_comb begin
    ctr     = centers[cmd.chan];
    d       = $signed({2'b00, avg}) - $signed({2'b00, ctr});
    dmag    = d[14] ? 14'(-d) : d[13:0];
    den     = d[14] ? $signed({5'd0, ctr}) : 18'(FullScale) - $signed({5'd0, ctr});
    den_bad = (den <= 0);
  end

  // Divider operand selection: average or rounded scale division.
  always_comb begin
    div_start = cmd.div_start;
    if (!cmd.div_sel) begin
      dividend = {3'd0, sums[cmd.chan]};
      divisor  = {8'd0, frame_count};
    end else begin
      dividend = 24'({dmag, 9'd0} - {dmag, 3'd0} - {dmag, 2'd0}) + 24'(den[15:0]);
      divisor  = {den[14:0], 1'b0};
    end
  end

  sasm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Scaled value with saturation and deadzone.
  logic [8:0]        q;
  logic signed [8:0] s;
  always_comb begin
    if (d == 0)        q = 9'd0;
    else if (den_bad)  q = d[14] ? 9'd0 : 9'(ScaleMax);
    else if (quotient > 24'(ScaleMax)) q = 9'(ScaleMax);
    else               q = quotient[8:0];
    s = d[14] ? -$signed(q) : $signed(q);
  end

  always_ff @(posedge clk) begin
    if (cmd.store_avg) avg <= quotient[ChanW-1:0];
    if (cmd.store_val) begin
      vals[cmd.chan] <= ($signed({1'b0, q}) < $signed({2'b0, deadzone})) ? '0 : s;
    end
  end

  // Axis mixing.
  logic signed [10:0] tx, ty, tz, rx, ry, rz, ysum;
  logic               xfull, yfull;
  always_comb begin
    xfull = 1'b1;
    yfull = 1'b1;
    for (int i = 0; i < NumChan; i++) begin
      if (!((vals[i] < 0 ? -vals[i] : vals[i]) > $signed({2'b0, deadzone}))) begin
        if (i % 2 == 0) xfull = 1'b0;
        else            yfull = 1'b0;
      end
    end
    tx   = 11'(vals[5]) - 11'(vals[1]);
    ty   = 11'(vals[7]) - 11'(vals[3]);
    rx   = 11'(vals[4]) - 11'(vals[0]);
    ry   = 11'(vals[2]) - 11'(vals[6]);
    tz   = '0;
    rz   = '0;
    ysum = 11'(vals[1]) + 11'(vals[3]) + 11'(vals[5]) + 11'(vals[7]);
    if (xfull) begin
      tz = -(11'(vals[0]) + 11'(vals[2]) + 11'(vals[4]) + 11'(vals[6]));
      tx = '0;
      ty = '0;
    end
    if (yfull) begin
      rz = (ysum + $signed({10'd0, ysum[10]})) >>> 1;
      rx = '0;
      ry = '0;
    end
    if (invert_mask[0]) tx = -tx;
    if (invert_mask[1]) ty = -ty;
    if (invert_mask[2]) tz = -tz;
    if (invert_mask[3]) rx = -rx;
    if (invert_mask[4]) ry = -ry;
    if (invert_mask[5]) rz = -rz;
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) result <= {rz[9:0], ry[9:0], rx[9:0], tz, ty[9:0], tx[9:0]};
  end

  assign status.div_done   = div_done;
  assign status.run_end    = run_end;
  assign status.run_mode   = run_mode;
  assign status.scale_skip = (d == 0) || den_bad;

endmodule

// File: sv/sasm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick mixer controller
// Sequences accumulation, per-channel divisions and result hand-off.
// ----------------------------------------------------------------------------
module sasm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_fire,
  input  logic                   out_fire,
  input  sasm_pkg::sasm_status_t status,
  output sasm_pkg::sasm_cmd_t    cmd,
  output logic                   in_ready,
  output logic                   out_valid
);
  import sasm_pkg::*;

  sasm_state_t state, state_next;
  logic [2:0]  chan, chan_next;
  logic        busy, busy_next;
  logic        chk, chk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chan  <= '0;
      busy  <= 1'b0;
      chk   <= 1'b0;
    end else begin
      state <= state_next;
      chan  <= chan_next;
      busy  <= busy_next;
      chk   <= chk_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    chan_next  = chan;
    busy_next  = busy;
    chk_next   = 1'b0;
    cmd        = '0;
    cmd.chan   = chan;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !chk;
        if (chk && status.run_end) begin
          state_next = ST_AVG;
          chan_next  = '0;
          busy_next  = 1'b0;
        end else if (in_fire) begin
          cmd.accum = 1'b1;
          chk_next  = 1'b1;
        end
      end
      ST_AVG: begin
        if (!busy) begin
          cmd.div_start = 1'b1;
          busy_next     = 1'b1;
        end else if (status.div_done) begin
          cmd.store_avg = 1'b1;
          busy_next     = 1'b0;
          state_next    = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.div_sel = 1'b1;
        if (status.run_mode) begin
          cmd.store_ctr = 1'b1;
          state_next    = ST_MIX;
        end else if (!busy && status.scale_skip) begin
          cmd.store_val = 1'b1;
          state_next    = ST_MIX;
        end else if (!busy) begin
          cmd.div_start = 1'b1;
          busy_next     = 1'b1;
        end else if (status.div_done) begin
          cmd.store_val = 1'b1;
          busy_next     = 1'b0;
          state_next    = ST_MIX;
        end
      end
      ST_MIX: begin
        if (chan != 3'(NumChan - 1)) begin
          chan_next  = chan + 3'd1;
          state_next = ST_AVG;
        end else begin
          cmd.clear_run = 1'b1;
          chan_next     = '0;
          if (status.run_mode) begin
            state_next = ST_IDLE;
          end else begin
            cmd.mix    = 1'b1;
            state_next = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A frame is never taken while a run is being finished.
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == ST_IDLE) else $error("frame taken while busy");
  // A result appears only after the last channel.
  a_out_after_mix: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_OUT) |-> $past(state) == ST_MIX && $past(chan) == 3'(NumChan - 1))
    else $error("result without full pass");
  // No division is ever started while one is still running.
  a_div_single: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !busy) else $error("division restarted");

endmodule

// File: sv/six_axis_stick_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Six-axis stick mixer
// Averages runs of stick frames, calibrates centers and mixes six axes.
// ----------------------------------------------------------------------------
// A frame is taken in one cycle and checked in the next, so a frame that does not
// end a run holds off the next frame while it is checked. A frame that ends a run
// holds the input for the per-channel work on the shared divider: each channel
// takes one averaging division and, in a measure run, one scaling division,
// skipped when the channel needs none, after which a measure result waits in
// its register until taken.
module six_axis_stick_mixer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
  input  logic [103:0] s_tdata,
  // operation
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // trans_x, trans_y, trans_z, rot_x, rot_y, rot_z, zero fill
  output logic [63:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);
  import sasm_pkg::*;

  sasm_cmd_t    cmd;
  sasm_status_t status;
  logic [60:0]  result;

  sasm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (s_tvalid && s_tready),
    .out_fire  (m_tvalid && m_tready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (s_tready),
    .out_valid (m_tvalid)
  );

  sasm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (s_tuser),
    .in_chan   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  assign m_tdata = {3'd0, result};

endmodule
